// ===== src/pws_pkg.sv =====
// Package for the phonetic word search: item types, register indexes, letter classes.
package pws_pkg;

  localparam int MAX_WORD_LETTERS_DEF = 24;
  localparam longint unsigned MAX_TEXT_BYTES_DEF = 64'd65536;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_CHARS_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_CHARS_MIDDLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_CHARS_HIGH   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LENGTH       = 2'd3;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  search_status;
    logic [15:0] match_offset;
  } out_item_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic [7:0] sound_class(input logic [7:0] c);
    logic [7:0] l;
    l = ((c >= "A") && (c <= "Z")) ? 8'(c + 8'd32) : c;
    case (l)
      "w":      return "v";
      "j":      return "g";
      "z":      return "s";
      "t":      return "d";
      "u":      return "o";
      "y":      return "i";
      "f", "p": return "b";
      "k", "q": return "c";
      default:  return l;
    endcase
  endfunction

endpackage

// ===== src/phonetic_word_search_top.sv =====
// Phonetic word search: streams text bytes and reports the first word matching the target.
//
// Usage: load the target letters and length through the write port (cfg_write_en,
// cfg_index, cfg_data) while the block is idle. Then send text bytes on the input
// channel (in_valid / in_stall / in_data), one transfer per byte, with end_of_text set
// on the last byte. One result transfer leaves on the output channel for that byte:
// found with the start offset, not found, or empty target.
// Timing: a byte is registered in the input register on transfer and processed from
// there; a last byte's result is loaded into the output register when that byte is
// processed, and out_valid rises with it.
// Throughput: one byte per cycle while in_stall is low; the per-byte step is one
// class compare and a letter counter update.
// Reset clears the target registers and all stream state. After each result the
// stream state returns to its reset values and the target is kept.
// While the output register holds an untaken result, ordinary bytes keep flowing;
// only a last byte waits in the input register, and in_stall rises behind it.
module phonetic_word_search_top #(
  parameter int MAX_WORD_LETTERS = pws_pkg::MAX_WORD_LETTERS_DEF,
  parameter longint unsigned MAX_TEXT_BYTES = pws_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pws_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pws_pkg::out_item_t                 out_data,
  input  logic                               cfg_write_en,
  input  logic [pws_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int POS_W = (MAX_TEXT_BYTES > 64'd2) ? $clog2(MAX_TEXT_BYTES) : 1;
  localparam int IDX_W = (MAX_WORD_LETTERS > 1) ? $clog2(MAX_WORD_LETTERS) : 1;
  localparam int LEN_W = pws_pkg::LEN_W;

  logic [7:0]       target_chars [MAX_WORD_LETTERS];
  logic [LEN_W-1:0] target_length;

  pws_pkg::in_item_t in_q;
  logic              in_valid_q;

  logic [POS_W-1:0] text_position, text_position_next;
  logic [LEN_W-1:0] letters_matched, letters_matched_next;
  logic             candidate_alive, candidate_alive_next;
  logic             after_separator, after_separator_next;
  logic [POS_W-1:0] candidate_start, candidate_start_next;
  logic             match_found, match_found_next;
  logic [POS_W-1:0] found_offset, found_offset_next;

  logic [LEN_W-1:0]   len;
  logic               empty;
  logic [7:0]         tgt_cur;
  logic [7:0]         c;
  logic               step;
  logic               advance;
  logic               fin_found;
  logic [POS_W-1:0]   fin_offset;
  logic [POS_W+15:0]  offset_wide;
  pws_pkg::out_item_t result;

  // target registers, only the letters the parameter allows are stored
  for (genvar k = 0; k < MAX_WORD_LETTERS; k++) begin : g_tgt
    always_ff @(posedge clk) begin
      if (rst) begin
        target_chars[k] <= 8'd0;
      end else if (cfg_write_en && (cfg_index == pws_pkg::CFG_INDEX_W'(k / 8))) begin
        target_chars[k] <= cfg_data[8*(k%8) +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_length <= '0;
    end else if (cfg_write_en && (cfg_index == pws_pkg::CFG_TARGET_LENGTH)) begin
      target_length <= cfg_data[LEN_W-1:0];
    end
  end

  assign advance  = !in_q.end_of_text || !out_valid || !out_stall;
  assign step     = in_valid_q && advance;
  assign in_stall = in_valid_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  assign len = (target_length > LEN_W'(MAX_WORD_LETTERS)) ? LEN_W'(MAX_WORD_LETTERS)
                                                          : target_length;
  assign empty = (len == '0) || ((len == LEN_W'(1)) && (target_chars[0] == pws_pkg::CHAR_SPACE));
  assign tgt_cur = target_chars[letters_matched[IDX_W-1:0]];
  assign c = in_q.text_char;

  always_comb begin
    text_position_next   = text_position;
    letters_matched_next = letters_matched;
    candidate_alive_next = candidate_alive;
    after_separator_next = after_separator;
    candidate_start_next = candidate_start;
    match_found_next     = match_found;
    found_offset_next    = found_offset;

    if (!match_found && !empty) begin
      if (candidate_alive) begin
        if (letters_matched >= len) begin
          if (!pws_pkg::is_letter(c)) begin
            match_found_next  = 1'b1;
            found_offset_next = candidate_start;
          end
          candidate_alive_next = 1'b0;
        end else if (pws_pkg::sound_class(c) == pws_pkg::sound_class(tgt_cur)) begin
          letters_matched_next = letters_matched + LEN_W'(1);
        end else begin
          candidate_alive_next = 1'b0;
        end
      end else if (after_separator && (c != pws_pkg::CHAR_SPACE)) begin
        candidate_start_next = text_position;
        if (pws_pkg::sound_class(c) == pws_pkg::sound_class(target_chars[0])) begin
          candidate_alive_next = 1'b1;
          letters_matched_next = LEN_W'(1);
        end
      end
    end
    after_separator_next = (c == pws_pkg::CHAR_SPACE);
    text_position_next = (text_position == POS_W'(MAX_TEXT_BYTES - 64'd1)) ? '0
                         : text_position + POS_W'(1);

    // candidate still alive at end of text counts if fully matched
    fin_found  = match_found_next ||
                 (!empty && candidate_alive_next && (letters_matched_next >= len));
    fin_offset = match_found_next ? found_offset_next : candidate_start_next;
    offset_wide = {16'd0, fin_offset};

    if (empty) begin
      result.search_status = pws_pkg::STATUS_EMPTY;
      result.match_offset  = 16'd0;
    end else if (fin_found) begin
      result.search_status = pws_pkg::STATUS_FOUND;
      result.match_offset  = offset_wide[15:0];
    end else begin
      result.search_status = pws_pkg::STATUS_NOT_FOUND;
      result.match_offset  = 16'd0;
    end

    if (in_q.end_of_text) begin
      text_position_next   = '0;
      letters_matched_next = '0;
      candidate_alive_next = 1'b0;
      after_separator_next = 1'b1;
      candidate_start_next = '0;
      match_found_next     = 1'b0;
      found_offset_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position   <= '0;
      letters_matched <= '0;
      candidate_alive <= 1'b0;
      after_separator <= 1'b1;
      candidate_start <= '0;
      match_found     <= 1'b0;
      found_offset    <= '0;
    end else if (step) begin
      text_position   <= text_position_next;
      letters_matched <= letters_matched_next;
      candidate_alive <= candidate_alive_next;
      after_separator <= after_separator_next;
      candidate_start <= candidate_start_next;
      match_found     <= match_found_next;
      found_offset    <= found_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_q.end_of_text) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_q.end_of_text) begin
      out_data <= result;
    end
  end

endmodule

// ===== src/pws_checker.sv =====
// Port-level checks for the phonetic word search, bound to the top level.
module pws_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input pws_pkg::in_item_t               in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input pws_pkg::out_item_t              out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transfer changed or dropped while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.search_status == pws_pkg::STATUS_FOUND) ||
                  (out_data.search_status == pws_pkg::STATUS_NOT_FOUND) ||
                  (out_data.search_status == pws_pkg::STATUS_EMPTY))
    else $error("undefined search status");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.search_status != pws_pkg::STATUS_FOUND)
      |-> (out_data.match_offset == 16'd0))
    else $error("offset set without a match");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or stall present right after reset");

endmodule

bind phonetic_word_search_top pws_checker u_pws_checker (.*);

// ===== dv/phonetic_word_search_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for phonetic_word_search_top: directed and random texts checked against a local predictor.
module phonetic_word_search_top_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES = 120;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  pws_pkg::in_item_t               in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  pws_pkg::out_item_t              out_data;
  logic                            cfg_write_en = 1'b0;
  logic [pws_pkg::CFG_INDEX_W-1:0] cfg_index = pws_pkg::CFG_TARGET_CHARS_LOW;
  logic [pws_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // target copy and stream state of the predictor
  logic [191:0] tgt_bits = '0;
  logic [4:0]   tgt_len = '0;
  logic [15:0]  scan_pos = '0;
  int           letters_hit = 0;
  bit           in_candidate = 1'b0;
  bit           prev_space = 1'b1;
  logic [15:0]  cand_offset = '0;
  bit           word_found = 1'b0;
  logic [15:0]  found_at = '0;

  pws_pkg::out_item_t expected_results[$];
  logic [7:0]   text_buf[$];
  int           mismatches = 0;
  int           bytes_sent = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  bit           calm = 1'b0;

  phonetic_word_search_top i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_alpha(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && (l >= "a") && (l <= "z");
  endfunction

  function automatic logic [7:0] fold_sound(input logic [7:0] c);
    logic [7:0] l;
    l = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    case (l)
      "v", "w":      return "v";
      "g", "j":      return "g";
      "s", "z":      return "s";
      "d", "t":      return "d";
      "o", "u":      return "o";
      "i", "y":      return "i";
      "b", "f", "p": return "b";
      "c", "k", "q": return "c";
      default:       return l;
    endcase
  endfunction

  function automatic logic [7:0] tgt_char(input int k);
    return tgt_bits[8*k +: 8];
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(8'h61, 8'h7a));
    if ($urandom_range(0, 1)) c = c & 8'hDF;
    return c;
  endfunction

  // random byte of the same sound class as t, random case
  function automatic logic [7:0] sound_alike(input logic [7:0] t);
    string grp;
    logic [7:0] l, pick;
    if (!is_alpha(t)) return t;
    l = t | 8'h20;
    case (l)
      "v", "w":      grp = "vw";
      "g", "j":      grp = "gj";
      "s", "z":      grp = "sz";
      "d", "t":      grp = "dt";
      "o", "u":      grp = "ou";
      "i", "y":      grp = "iy";
      "b", "f", "p": grp = "bfp";
      "c", "k", "q": grp = "ckq";
      default:       grp = "";
    endcase
    pick = (grp.len() == 0) ? l : grp[$urandom_range(0, grp.len() - 1)];
    if ($urandom_range(0, 1)) pick = pick & 8'hDF;
    return pick;
  endfunction

  function automatic logic [191:0] pack_string(input string s);
    logic [191:0] bits;
    bits = '0;
    for (int k = 0; k < s.len() && k < 24; k++) bits[8*k +: 8] = s[k];
    return bits;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic last);
    int len;
    bit empty;
    pws_pkg::out_item_t res;
    len = (tgt_len > 24) ? 24 : int'(tgt_len);
    empty = (len == 0) || (len == 1 && tgt_char(0) == pws_pkg::CHAR_SPACE);
    if (!word_found && !empty) begin
      if (in_candidate) begin
        if (letters_hit >= len) begin
          if (!is_alpha(c)) begin
            word_found = 1'b1;
            found_at = cand_offset;
          end
          in_candidate = 1'b0;
        end else if (fold_sound(c) == fold_sound(tgt_char(letters_hit))) begin
          letters_hit++;
        end else begin
          in_candidate = 1'b0;
        end
      end else if (prev_space && c != pws_pkg::CHAR_SPACE) begin
        cand_offset = scan_pos;
        if (fold_sound(c) == fold_sound(tgt_char(0))) begin
          in_candidate = 1'b1;
          letters_hit = 1;
        end
      end
    end
    prev_space = (c == pws_pkg::CHAR_SPACE);
    scan_pos++;
    if (last) begin
      if (!word_found && !empty && in_candidate && letters_hit >= len) begin
        word_found = 1'b1;
        found_at = cand_offset;
      end
      res.search_status = empty ? pws_pkg::STATUS_EMPTY
                        : (word_found ? pws_pkg::STATUS_FOUND : pws_pkg::STATUS_NOT_FOUND);
      res.match_offset = (!empty && word_found) ? found_at : 16'd0;
      expected_results.push_back(res);
      scan_pos = '0;
      letters_hit = 0;
      in_candidate = 1'b0;
      prev_space = 1'b1;
      cand_offset = '0;
      word_found = 1'b0;
      found_at = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{text_char: c, end_of_text: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [pws_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [pws_pkg::CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_target(input logic [191:0] chars, input logic [4:0] len);
    drain_results();
    put_reg(pws_pkg::CFG_TARGET_CHARS_LOW, chars[63:0]);
    put_reg(pws_pkg::CFG_TARGET_CHARS_MIDDLE, chars[127:64]);
    put_reg(pws_pkg::CFG_TARGET_CHARS_HIGH, chars[191:128]);
    put_reg(pws_pkg::CFG_TARGET_LENGTH, pws_pkg::CFG_DATA_W'(len));
    cfg_write_en <= 1'b0;
    tgt_bits = chars;
    tgt_len = len;
  endtask

  // words: sound-alike copies of the target, near misses, random letters, random bytes
  task automatic build_random_text();
    int len_eff, words, n, r;
    text_buf.delete();
    len_eff = (tgt_len > 24) ? 24 : int'(tgt_len);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) text_buf.push_back(pws_pkg::CHAR_SPACE);
    words = $urandom_range(1, 6);
    for (int w = 0; w < words; w++) begin
      r = $urandom_range(0, 99);
      if (len_eff > 0 && r < 62) begin
        n = (r >= 55 && len_eff > 1) ? len_eff - 1 : len_eff;
        for (int k = 0; k < n; k++) text_buf.push_back(sound_alike(tgt_char(k)));
        if (r >= 35 && r < 45) text_buf.push_back(rand_letter());
        if (r >= 45 && r < 55) text_buf[text_buf.size() - 1 - $urandom_range(0, n - 1)] = rand_letter();
      end else if (r < 95) begin
        repeat ($urandom_range(1, 8)) text_buf.push_back(rand_letter());
      end else begin
        repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (w < words - 1 || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 20) text_buf.push_back(8'($urandom_range(8'h21, 8'h3f)));
        if (r >= 10) repeat ($urandom_range(1, 3)) text_buf.push_back(pws_pkg::CHAR_SPACE);
      end
    end
  endtask

  task automatic test_empty_target();
    send_string("ab");
    set_target(pack_string(" "), 5'd1);
    send_string(" x");
  endtask

  task automatic test_sound_classes();
    set_target(pack_string("vgsdoibc"), 5'd8);
    send_string("wJzTuYpQ");
  endtask

  // mid-word hit, letter after match, first of several matches, one-byte text
  task automatic test_word_boundaries();
    set_target(pack_string("cat"), 5'd3);
    send_string("  scat katz kat,cad");
    send_string("x");
  endtask

  task automatic test_raw_bytes();
    set_target({176'd0, 8'h31, 8'hE9}, 5'd2);
    text_buf = {8'hE9, 8'h31, 8'hFF};
    send_text();
  endtask

  task automatic test_long_target();
    logic [191:0] chars;
    for (int k = 0; k < 24; k++) chars[8*k +: 8] = rand_letter();
    set_target(chars, 5'd31);
    text_buf.delete();
    for (int k = 0; k < 24; k++) text_buf.push_back(sound_alike(chars[8*k +: 8]));
    send_text();
  endtask

  task automatic test_random_texts();
    logic [191:0] chars;
    logic [4:0] len;
    int start;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int k = 0; k < 24; k++) chars[8*k +: 8] = rand_letter();
      case (phase)
        0: begin chars = '0; len = 5'd0; end
        1: begin chars[7:0] = pws_pkg::CHAR_SPACE; len = 5'd1; end
        2: len = 5'd24;
        3: len = 5'd31;
        4: len = 5'd1;
        5: begin
          for (int k = 0; k < 24; k++) chars[8*k +: 8] = 8'($urandom_range(0, 255));
          len = 5'($urandom_range(1, 4));
        end
        6: begin chars = '1; len = 5'd3; end
        default: len = 5'($urandom_range(1, 7));
      endcase
      set_target(chars, len);
      calm = (phase % 4 == 3);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        build_random_text();
        send_text();
      end
      calm = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    pws_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result transfer: status %0d offset %0d",
                             out_data.search_status, out_data.match_offset));
      end else begin
        want = expected_results.pop_front();
        if (out_data.search_status !== want.search_status)
          flag_error($sformatf("search_status: expected %0d, got %0d",
                               want.search_status, out_data.search_status));
        if (out_data.match_offset !== want.match_offset)
          flag_error($sformatf("match_offset: expected %0d, got %0d",
                               want.match_offset, out_data.match_offset));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_target();
    test_sound_classes();
    test_word_boundaries();
    test_raw_bytes();
    test_long_target();
    test_random_texts();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
